>>> rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  // block numbers are 10 bits wide, so at most 1024 blocks can be named
  localparam int BLK_W          = 10;
  localparam int CNT_W          = 11;
  localparam int NUM_SPACE      = 1024;
  localparam int MAX_BLOCKS_DEF = 1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ALREADY_FREE = 2'd1,
    ST_RANGE        = 2'd2,
    ST_FULL         = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [BLK_W-1:0] block_no;
  } in_word_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_no_out;
    status_t          status;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/fifo_free_list_block_allocator_unit.sv
`default_nettype none

// channel  dir  handshake             word
// -------  ---  --------------------  ----------------------------------
// in       in   in_valid / in_ready   in_data   {op, block_no}
// out      out  out_valid / out_ready out_data  {block_no_out, status}
//
// each word passes an accept step, which reads the link and free-mark memories,
// then a decide step that writes the free mark, and on an append the link, back;
// no word is accepted until the decide step of the last one is done
// a result waiting in the output register does not block the next accept;
// the decide step holds only while that register is still full
// rst_n (synchronous) empties the list, high-water count to one, no clearing pass

module fifo_free_list_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  // usable blocks are capped by the 10-bit block number space
  localparam int DEPTH = (MAX_BLOCKS < NUM_SPACE) ? MAX_BLOCKS : NUM_SPACE;
  localparam int IW    = $clog2(DEPTH);

  // next-link memory, written only when a block gains a successor
  logic             link_rd_en;
  logic [IW-1:0]    link_rd_addr;
  logic [BLK_W-1:0] link_rd_data;
  logic             link_wr_en;
  logic [IW-1:0]    link_wr_addr;
  logic [BLK_W-1:0] link_wr_data;

  // free-mark memory, one bit per block, valid below the high-water count
  logic             mark_rd_en;
  logic [IW-1:0]    mark_rd_addr;
  logic             mark_rd_data;
  logic             mark_wr_en;
  logic [IW-1:0]    mark_wr_addr;
  logic             mark_wr_data;

  ffba_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .link_rd_en   (link_rd_en),
    .link_rd_addr (link_rd_addr),
    .link_rd_data (link_rd_data),
    .link_wr_en   (link_wr_en),
    .link_wr_addr (link_wr_addr),
    .link_wr_data (link_wr_data),
    .mark_rd_en   (mark_rd_en),
    .mark_rd_addr (mark_rd_addr),
    .mark_rd_data (mark_rd_data),
    .mark_wr_en   (mark_wr_en),
    .mark_wr_addr (mark_wr_addr),
    .mark_wr_data (mark_wr_data)
  );

  ffba_ram #(
    .WIDTH(BLK_W),
    .DEPTH(DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data)
  );

  ffba_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_mark_ram (
    .clk     (clk),
    .rd_en   (mark_rd_en),
    .rd_addr (mark_rd_addr),
    .rd_data (mark_rd_data),
    .wr_en   (mark_wr_en),
    .wr_addr (mark_wr_addr),
    .wr_data (mark_wr_data)
  );

`ifndef SYNTH
  // reads and write-backs never share a cycle, so no forwarding is needed
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (link_rd_en || mark_rd_en) |-> !(link_wr_en || mark_wr_en))
    else $error("memory read and write-back in the same cycle");

  // an append to the list always marks the appended block free
  a_append_marks_free: assert property (@(posedge clk) disable iff (!rst_n)
    link_wr_en |-> (mark_wr_en && mark_wr_data))
    else $error("link written without setting the free mark");

  // the cycle after an accept is the decide step, no second accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted during the decide step");

  // every write-back comes with a result
  a_write_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    mark_wr_en |=> out_valid)
    else $error("state written without a result word");
`endif

endmodule

`default_nettype wire

>>> rtl/ffba_ram.sv
`default_nettype none

module ffba_ram
  import ffba_pkg::*;
#(
  parameter int WIDTH = BLK_W,
  parameter int DEPTH = MAX_BLOCKS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl
  import ffba_pkg::*;
#(
  parameter int DEPTH = MAX_BLOCKS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_word_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_word_t                     out_data,
  output logic                          link_rd_en,
  output logic      [$clog2(DEPTH)-1:0] link_rd_addr,
  input  wire logic [BLK_W-1:0]         link_rd_data,
  output logic                          link_wr_en,
  output logic      [$clog2(DEPTH)-1:0] link_wr_addr,
  output logic      [BLK_W-1:0]         link_wr_data,
  output logic                          mark_rd_en,
  output logic      [$clog2(DEPTH)-1:0] mark_rd_addr,
  input  wire logic                     mark_rd_data,
  output logic                          mark_wr_en,
  output logic      [$clog2(DEPTH)-1:0] mark_wr_addr,
  output logic                          mark_wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH);

  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [BLK_W-1:0] blk_r;
  logic [BLK_W-1:0] head_r, head_nxt;
  logic [BLK_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;
  logic             in_accept;
  logic [BLK_W-1:0] res_blk;
  status_t          res_st;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // both memories are read when a word is taken
  assign link_rd_en   = in_accept;
  assign link_rd_addr = head_r[IW-1:0];
  assign mark_rd_en   = in_accept;
  assign mark_rd_addr = in_data.block_no[IW-1:0];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      used_r      <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_accept) begin
      op_r  <= in_data.op;
      blk_r <= in_data.block_no;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    link_wr_en    = 1'b0;
    link_wr_addr  = tail_r[IW-1:0];
    link_wr_data  = blk_r;
    mark_wr_en    = 1'b0;
    mark_wr_addr  = blk_r[IW-1:0];
    mark_wr_data  = 1'b0;
    res_blk       = '0;
    res_st        = ST_OK;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (op_r)
            OP_ALLOC: begin
              if (!empty_r) begin
                // pop the oldest free block
                res_blk      = head_r;
                mark_wr_en   = 1'b1;
                mark_wr_addr = head_r[IW-1:0];
                if (head_r != tail_r) begin
                  head_nxt = link_rd_data;
                end else begin
                  empty_nxt = 1'b1;
                  head_nxt  = '0;
                  tail_nxt  = '0;
                end
              end else if (used_r >= LIMIT) begin
                res_st = ST_FULL;
              end else begin
                // fresh block: its free mark is written here for the first time
                res_blk      = used_r[BLK_W-1:0];
                mark_wr_en   = 1'b1;
                mark_wr_addr = used_r[IW-1:0];
                used_nxt     = used_r + CNT_W'(1);
              end
            end
            OP_FREE: begin
              if (blk_r == '0 || {1'b0, blk_r} >= used_r) begin
                res_st = ST_RANGE;
              end else if (mark_rd_data) begin
                res_st = ST_ALREADY_FREE;
              end else begin
                if (!empty_r) begin
                  link_wr_en = 1'b1;
                end else begin
                  head_nxt = blk_r;
                end
                tail_nxt     = blk_r;
                empty_nxt    = 1'b0;
                mark_wr_en   = 1'b1;
                mark_wr_data = 1'b1;
              end
            end
            default: begin
              res_st = ST_OK;
            end
          endcase
          out_data_nxt.block_no_out = res_blk;
          out_data_nxt.status       = res_st;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> dv/fifo_free_list_block_allocator_unit_tb.sv
`timescale 1ns / 100ps

module fifo_free_list_block_allocator_unit_tb;
  import ffba_pkg::*;

  // store size under test and how many block numbers can be named
  localparam int NBLK        = MAX_BLOCKS_DEF;
  localparam int BLOCK_LIMIT = (NBLK < NUM_SPACE) ? NBLK : NUM_SPACE;
  localparam int N_DIRECTED  = 20;
  localparam int N_PER_PHASE = 410;
  localparam int CYCLE_LIMIT = 400000;
  // allocate share until the store has reported full four times, then after
  localparam int FILL_PCT    = 95;
  localparam int MIX_PCT     = 55;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      in_ready;

  fifo_free_list_block_allocator_unit #(
    .MAX_BLOCKS(NBLK)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // shadow copy of the allocator
  // ---------------------------------------------------------------------

  bit            free_mark  [BLOCK_LIMIT];
  logic [9:0]    succ_blk   [BLOCK_LIMIT];
  bit            succ_valid [BLOCK_LIMIT];
  logic [9:0]    head_blk;
  logic [9:0]    tail_blk;
  bit            list_drained;
  int            high_water;

  // results still owed by the block, oldest first
  out_word_t     results_due[$];

  int            n_err;
  int            full_hits;
  int            cycle_cnt;
  int            snd_idle;
  int            rcv_stall;

  // directed rows may carry a hand-typed result that overrides the shadow copy
  bit            row_typed;
  out_word_t     row_exp;

  function automatic void clear_shadow();
    for (int i = 0; i < BLOCK_LIMIT; i++) begin
      free_mark[i]  = 1'b0;
      succ_blk[i]   = '0;
      succ_valid[i] = 1'b0;
    end
    head_blk     = '0;
    tail_blk     = '0;
    list_drained = 1'b1;
    high_water   = 1;
  endfunction

  // applies one request word to the shadow copy, returns the result word
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t res;
    int        b;
    res        = '0;
    res.status = ST_OK;
    if (w.op == OP_ALLOC) begin
      if (!list_drained) begin
        // oldest free block leaves from the head
        res.block_no_out = head_blk;
        free_mark[head_blk] = 1'b0;
        if (succ_valid[head_blk]) begin
          head_blk = succ_blk[head_blk];
        end else begin
          // last one out, list back to its empty shape
          list_drained = 1'b1;
          head_blk     = '0;
          tail_blk     = '0;
        end
      end else if (high_water >= BLOCK_LIMIT) begin
        res.status = ST_FULL;
      end else begin
        // fresh block from above the high-water mark
        res.block_no_out = 10'(high_water);
        high_water++;
      end
    end else begin
      b = int'(w.block_no);
      if (b == 0 || b >= high_water) begin
        res.status = ST_RANGE;
      end else if (free_mark[b]) begin
        res.status = ST_ALREADY_FREE;
      end else begin
        // append at the tail
        if (!list_drained) begin
          succ_blk[tail_blk]   = 10'(b);
          succ_valid[tail_blk] = 1'b1;
        end else begin
          head_blk = 10'(b);
        end
        tail_blk      = 10'(b);
        succ_valid[b] = 1'b0;
        succ_blk[b]   = '0;
        free_mark[b]  = 1'b1;
        list_drained  = 1'b0;
      end
    end
    return res;
  endfunction

  // random request shaped by the shadow state: allocations at alloc_pct, else
  // mostly legal frees of blocks in use, some double frees, some arbitrary ones
  function automatic in_word_t pick_request(int alloc_pct);
    in_word_t w;
    int       r;
    int       b;
    w.block_no = 10'($urandom_range(1023));
    w.op       = OP_ALLOC;
    if ($urandom_range(99) < alloc_pct) return w;
    w.op = OP_FREE;
    r    = $urandom_range(99);
    if (r < 10) return w;
    if (r < 20 && !list_drained) begin
      w.block_no = $urandom_range(1) ? head_blk : tail_blk;
      return w;
    end
    if (high_water > 1) begin
      for (int t = 0; t < 8; t++) begin
        b = $urandom_range(high_water - 1, 1);
        if (!free_mark[b]) begin
          w.block_no = 10'(b);
          return w;
        end
      end
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // monitor: results are checked before the same edge's request is taken
  // ---------------------------------------------------------------------

  out_word_t exp_w;
  out_word_t new_w;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing expected: block_no_out %0d status %0d",
                 out_data.block_no_out, out_data.status);
          n_err++;
        end else begin
          exp_w = results_due.pop_front();
          if (out_data.block_no_out !== exp_w.block_no_out) begin
            $error("block_no_out mismatch: expected %0d, actual %0d",
                   exp_w.block_no_out, out_data.block_no_out);
            n_err++;
          end
          if (out_data.status !== exp_w.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_w.status, out_data.status);
            n_err++;
          end
        end
      end
      if (in_valid && in_ready) begin
        new_w = apply_request(in_data);
        if (row_typed) new_w = row_exp;
        if (new_w.status == ST_FULL) full_hits++;
        results_due.push_back(new_w);
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall);
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------

  // called at a falling edge; returns at the falling edge after the accept
  // with valid still high, so the next call either keeps it or drops it while idling
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // sender holds off until every owed result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  typedef struct {
    op_t        op;
    logic [9:0] blk;
    bit         typed;
    logic [9:0] e_blk;
    status_t    e_st;
  } dir_row_t;

  dir_row_t directed_rows[N_DIRECTED];

  int snd_by_phase[4] = '{0, 74, 0, 10};
  int rcv_by_phase[4] = '{0, 0, 74, 10};

  initial begin
    in_word_t w;
    n_err     = 0;
    full_hits = 0;
    cycle_cnt = 0;
    snd_idle  = 0;
    rcv_stall = 0;
    row_typed = 1'b0;
    row_exp   = '0;
    clear_shadow();

    directed_rows = '{
      // header, unused low and top block numbers right after reset
      '{OP_FREE,  10'd0,    1'b1, 10'd0, ST_RANGE},
      '{OP_FREE,  10'd1,    1'b1, 10'd0, ST_RANGE},
      '{OP_FREE,  10'd1023, 1'b1, 10'd0, ST_RANGE},
      // fresh blocks in order, block_no ignored
      '{OP_ALLOC, 10'd1023, 1'b1, 10'd1, ST_OK},
      '{OP_ALLOC, 10'd0,    1'b1, 10'd2, ST_OK},
      '{OP_ALLOC, 10'd682,  1'b1, 10'd3, ST_OK},
      // free, then double free, then just above the high-water mark
      '{OP_FREE,  10'd2,    1'b0, 10'd0, ST_OK},
      '{OP_FREE,  10'd2,    1'b1, 10'd0, ST_ALREADY_FREE},
      '{OP_FREE,  10'd4,    1'b1, 10'd0, ST_RANGE},
      '{OP_FREE,  10'd1,    1'b0, 10'd0, ST_OK},
      '{OP_FREE,  10'd3,    1'b0, 10'd0, ST_OK},
      // list comes back oldest first and drains
      '{OP_ALLOC, 10'd341,  1'b0, 10'd0, ST_OK},
      '{OP_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK},
      '{OP_ALLOC, 10'd1023, 1'b0, 10'd0, ST_OK},
      // drained list falls back to a fresh block
      '{OP_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK},
      '{OP_FREE,  10'd0,    1'b1, 10'd0, ST_RANGE},
      '{OP_FREE,  10'd4,    1'b0, 10'd0, ST_OK},
      '{OP_FREE,  10'd4,    1'b1, 10'd0, ST_ALREADY_FREE},
      '{OP_ALLOC, 10'd512,  1'b0, 10'd0, ST_OK},
      '{OP_FREE,  10'd1023, 1'b1, 10'd0, ST_RANGE}
    };

    // reset once, released at a falling edge
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part, no idling
    foreach (directed_rows[i]) begin
      w.op       = directed_rows[i].op;
      w.block_no = directed_rows[i].blk;
      row_typed  = directed_rows[i].typed;
      row_exp.block_no_out = directed_rows[i].e_blk;
      row_exp.status       = directed_rows[i].e_st;
      send_word(w);
    end
    row_typed = 1'b0;
    drain_results();

    // random part: fill the store until it has reported full four times,
    // then a balanced mix; each phase ends with a full drain
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle  = snd_by_phase[ph];
      rcv_stall = rcv_by_phase[ph];
      for (int i = 0; i < N_PER_PHASE; i++) begin
        send_word(pick_request(full_hits < 4 ? FILL_PCT : MIX_PCT));
      end
      drain_results();
    end

    rcv_stall = 0;
    repeat (20) @(negedge clk);
    if (n_err == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
